FILE: design/greedy_iou_nms_top_two_macros.svh
// assertion macros for the checker file
`ifndef GREEDY_IOU_NMS_TOP_TWO_MACROS_SVH
`define GREEDY_IOU_NMS_TOP_TWO_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define GNMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gnms check failed: same-cycle rule");

// consequent checked in the cycle after the antecedent
`define GNMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gnms check failed: next-cycle rule");

`endif

FILE: design/gnms_pkg.sv
// shared types and constants for the two-box iou suppression block
`timescale 1ns / 1ps

package gnms_pkg;

	localparam int EDGE_W    = 16;
	localparam int SCORE_W   = 17;
	localparam int ID_W      = 16;
	localparam int LIMIT_W   = 17;
	localparam int KEEP_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 1;
	localparam int FRAC_W    = 16;
	localparam int MUL_W     = 32;

	localparam logic [SCORE_W-1:0] SCORE_ONE   = 17'd65536;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd29491;
	localparam logic [KEEP_W-1:0]  KEEP_RESET  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IOU_LIMIT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 1'd1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVERTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SCORE    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [EDGE_W-1:0]  left_edge;
		logic [EDGE_W-1:0]  top_edge;
		logic [EDGE_W-1:0]  right_bound;
		logic [EDGE_W-1:0]  bottom_bound;
		logic [SCORE_W-1:0] confidence;
		logic [ID_W-1:0]    cand_id;
		logic               final_item;
	} cand_beat_t;

	typedef struct packed {
		logic [EDGE_W-1:0]   out_left;
		logic [EDGE_W-1:0]   out_top;
		logic [EDGE_W-1:0]   out_right;
		logic [EDGE_W-1:0]   out_bottom;
		logic [SCORE_W-1:0]  out_score;
		logic [ID_W-1:0]     out_id;
		logic                rank;
		logic [STATUS_W-1:0] status;
		logic                last_out;
	} result_beat_t;

	typedef struct packed {
		logic               start;
		logic [LIMIT_W-1:0] limit;
	} iou_req_t;

	typedef struct packed {
		logic done;
		logic suppress;
	} iou_rsp_t;

endpackage

FILE: design/gnms_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module gnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/gnms_iou.sv
// sequenced iou threshold test built around one shared multiplier
`timescale 1ns / 1ps

module gnms_iou #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gnms_pkg::iou_req_t      req,
	input  logic [4*COORD_BITS-1:0] best_box,
	input  logic [4*COORD_BITS-1:0] cand_box,
	output gnms_pkg::iou_rsp_t      rsp
);

	localparam int CB     = COORD_BITS;
	localparam int MW     = gnms_pkg::MUL_W;
	localparam int PW     = 2 * MW;
	localparam int AREA_W = 2 * CB;
	localparam int UNI_W  = 2 * CB + 1;
	localparam int LIM_W  = gnms_pkg::LIMIT_W;
	localparam int RHS_W  = LIM_W + UNI_W;
	localparam int FW     = gnms_pkg::FRAC_W;

	typedef enum logic [2:0] {
		IDLE, MUL_INTER, MUL_AREA_B, MUL_AREA_C, SUB_INTER, MUL_RHS_LO, MUL_RHS_HI, COMPARE
	} iou_state_t;

	iou_state_t state_q;
	logic       done_q;
	logic       sup_q;

	logic [CB-1:0]     iw_q, ih_q, bw_q, bh_q, cw_q, ch_q;
	logic [AREA_W-1:0] inter_q, area_q;
	logic [UNI_W-1:0]  uni_q;
	logic [RHS_W-1:0]  rhs_q;
	logic [LIM_W-1:0]  limit_q;

	logic [CB-1:0] bl, bt, br, bb, cl, ct, cr, cb_e;
	logic [CB-1:0] ix_lo, ix_hi, iy_lo, iy_hi, iw, ih;
	logic [MW-1:0] mul_a, mul_b;
	logic [PW-1:0] prod, uni_ext;

	always_comb begin
		bl    = best_box[4*CB-1 -: CB];
		bt    = best_box[3*CB-1 -: CB];
		br    = best_box[2*CB-1 -: CB];
		bb    = best_box[CB-1:0];
		cl    = cand_box[4*CB-1 -: CB];
		ct    = cand_box[3*CB-1 -: CB];
		cr    = cand_box[2*CB-1 -: CB];
		cb_e  = cand_box[CB-1:0];
		ix_lo = (bl > cl) ? bl : cl;
		ix_hi = (br < cr) ? br : cr;
		iy_lo = (bt > ct) ? bt : ct;
		iy_hi = (bb < cb_e) ? bb : cb_e;
		iw    = (ix_hi > ix_lo) ? ix_hi - ix_lo : '0;
		ih    = (iy_hi > iy_lo) ? iy_hi - iy_lo : '0;
	end

	// operand select for the shared multiplier
	always_comb begin
		uni_ext = PW'(uni_q);
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			MUL_INTER: begin
				mul_a = MW'(iw_q);
				mul_b = MW'(ih_q);
			end
			MUL_AREA_B: begin
				mul_a = MW'(bw_q);
				mul_b = MW'(bh_q);
			end
			MUL_AREA_C: begin
				mul_a = MW'(cw_q);
				mul_b = MW'(ch_q);
			end
			MUL_RHS_LO: begin
				mul_a = MW'(limit_q);
				mul_b = uni_ext[MW-1:0];
			end
			MUL_RHS_HI: begin
				mul_a = MW'(limit_q);
				mul_b = uni_ext[PW-1:MW];
			end
			default: begin
			end
		endcase
		prod = PW'(mul_a) * PW'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done_q  <= 1'b0;
			sup_q   <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					done_q <= 1'b0;
					if (req.start) begin
						state_q <= MUL_INTER;
					end
				end
				MUL_INTER:  state_q <= MUL_AREA_B;
				MUL_AREA_B: state_q <= MUL_AREA_C;
				MUL_AREA_C: state_q <= SUB_INTER;
				SUB_INTER:  state_q <= MUL_RHS_LO;
				MUL_RHS_LO: state_q <= MUL_RHS_HI;
				MUL_RHS_HI: state_q <= COMPARE;
				COMPARE: begin
					// zero union counts as no overlap
					done_q  <= 1'b1;
					sup_q   <= (uni_q != '0) &&
						(RHS_W'({inter_q, {FW{1'b0}}}) > rhs_q);
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			IDLE: begin
				if (req.start) begin
					iw_q    <= iw;
					ih_q    <= ih;
					bw_q    <= br - bl;
					bh_q    <= bb - bt;
					cw_q    <= cr - cl;
					ch_q    <= cb_e - ct;
					limit_q <= req.limit;
				end
			end
			MUL_INTER:  inter_q <= AREA_W'(prod);
			MUL_AREA_B: area_q  <= AREA_W'(prod);
			MUL_AREA_C: uni_q   <= UNI_W'(area_q) + UNI_W'(prod);
			SUB_INTER:  uni_q   <= uni_q - UNI_W'(inter_q);
			MUL_RHS_LO: rhs_q   <= RHS_W'(prod);
			MUL_RHS_HI: rhs_q   <= rhs_q + RHS_W'({prod, {MW{1'b0}}});
			default: begin
			end
		endcase
	end

	assign rsp.done     = done_q;
	assign rsp.suppress = sup_q;

endmodule

FILE: design/greedy_iou_nms_top_two.sv
// top level of the greedy two-box iou suppression block
//
//  channel  | dir | handshake                  | beat
//  ---------+-----+----------------------------+------------------------------------
//  cand     | in  | cand_valid / cand_stall    | one candidate box, score, id, final
//  result   | out | result_valid / result_stall| one kept box or one error beat
//  cfg      | in  | cfg_we (no wait)           | cfg_index selects iou_limit or keep
//
//  loading accepts one candidate beat per cycle; a beat that passes its checks in
//  an error-free set is written to the store; the running best is tracked in registers
//  after the final beat the store is walked once through the shared iou unit, which
//  tests each stored candidate other than the best and skips the best slot
//  keep count below two skips the walk; an error or an empty set goes straight to
//  the error beat; reset clears control, the set counters, the output register and
//  the configuration; the store and the kept boxes need no clearing
//  cand_stall is high from the final beat until the last result beat is loaded into
//  the output register; result_stall holds that register and the emit state behind it
`timescale 1ns / 1ps

module greedy_iou_nms_top_two #(
	parameter int STORE_DEPTH = 1024,
	parameter int COORD_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cand_valid,
	output logic                              cand_stall,
	input  gnms_pkg::cand_beat_t              cand,
	output logic                              result_valid,
	input  logic                              result_stall,
	output gnms_pkg::result_beat_t            result,
	input  logic                              cfg_we,
	input  logic [gnms_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gnms_pkg::CFG_W-1:0]        cfg_data
);

	localparam int CB      = COORD_BITS;
	localparam int AW      = $clog2(STORE_DEPTH);
	localparam int CW      = $clog2(STORE_DEPTH + 1);
	localparam int BOX_W   = 4 * CB;
	localparam int SW      = gnms_pkg::SCORE_W;
	localparam int IW      = gnms_pkg::ID_W;
	localparam int EW      = gnms_pkg::EDGE_W;
	localparam int ENTRY_W = BOX_W + SW + IW;

	typedef enum logic [2:0] {
		LOAD, SCAN_RD, SCAN_GO, SCAN_WAIT, EMIT_BEST, EMIT_SECOND, EMIT_ERR
	} state_t;

	state_t state_q;

	// set bookkeeping
	logic [CW-1:0]                  fill_q;
	logic [AW-1:0]                  best_slot_q;
	logic [gnms_pkg::STATUS_W-1:0]  err_q;
	logic [CW-1:0]                  scan_q;
	logic                           have2_q;

	// configuration
	logic [gnms_pkg::LIMIT_W-1:0] limit_q;
	logic [gnms_pkg::KEEP_W-1:0]  keep_q;

	// kept box registers
	logic [BOX_W-1:0] best_box_q, sec_box_q;
	logic [SW-1:0]    best_score_q, sec_score_q;
	logic [IW-1:0]    best_id_q, sec_id_q;

	// output register
	logic                   result_valid_q;
	gnms_pkg::result_beat_t result_q;

	logic [CB-1:0]                 c_l, c_t, c_r, c_b;
	logic [BOX_W-1:0]              cand_box;
	logic [gnms_pkg::STATUS_W-1:0] code, err_next;
	logic                          cand_fire, store, ahead, sec_ahead, out_free, out_load;
	logic [CW-1:0]                 fill_inc, fill_after;

	logic [ENTRY_W-1:0] rdata;
	logic [BOX_W-1:0]   rd_box;
	logic [SW-1:0]      rd_score;
	logic [IW-1:0]      rd_id;
	logic               rd_en;

	gnms_pkg::iou_req_t     iou_req;
	gnms_pkg::iou_rsp_t     iou_rsp;
	gnms_pkg::result_beat_t best_beat, sec_beat, err_beat;

	function automatic gnms_pkg::result_beat_t make_beat(
		input logic [BOX_W-1:0] box,
		input logic [SW-1:0]    score,
		input logic [IW-1:0]    id,
		input logic             rank_bit,
		input logic             last_bit
	);
		gnms_pkg::result_beat_t beat;
		beat            = '0;
		beat.out_left   = EW'(box[4*CB-1 -: CB]);
		beat.out_top    = EW'(box[3*CB-1 -: CB]);
		beat.out_right  = EW'(box[2*CB-1 -: CB]);
		beat.out_bottom = EW'(box[CB-1:0]);
		beat.out_score  = score;
		beat.out_id     = id;
		beat.rank       = rank_bit;
		beat.status     = gnms_pkg::ST_OK;
		beat.last_out   = last_bit;
		return beat;
	endfunction

	// edges are taken in their low COORD_BITS bits
	assign c_l      = CB'(cand.left_edge);
	assign c_t      = CB'(cand.top_edge);
	assign c_r      = CB'(cand.right_bound);
	assign c_b      = CB'(cand.bottom_bound);
	assign cand_box = {c_l, c_t, c_r, c_b};

	assign cand_stall = (state_q != LOAD);
	assign cand_fire  = cand_valid && !cand_stall;
	assign out_free   = !result_valid_q || !result_stall;
	assign out_load   = out_free &&
		(state_q == EMIT_BEST || state_q == EMIT_SECOND || state_q == EMIT_ERR);

	always_comb begin
		// first failing check wins: inverted box, then score, then full store
		if (c_r < c_l || c_b < c_t) begin
			code = gnms_pkg::ST_INVERTED;
		end else if (cand.confidence > gnms_pkg::SCORE_ONE) begin
			code = gnms_pkg::ST_SCORE;
		end else if (fill_q >= CW'(STORE_DEPTH)) begin
			code = gnms_pkg::ST_FULL;
		end else begin
			code = gnms_pkg::ST_OK;
		end
		// the first error of the set sticks
		err_next   = (err_q == gnms_pkg::ST_OK) ? code : err_q;
		store      = cand_fire && (code == gnms_pkg::ST_OK) && (err_q == gnms_pkg::ST_OK);
		fill_inc   = fill_q + 1'b1;
		fill_after = store ? fill_inc : fill_q;
		// higher score wins, lower id breaks a tie, earlier arrival keeps a full tie
		ahead      = (fill_q == '0) || (cand.confidence > best_score_q) ||
			((cand.confidence == best_score_q) && (cand.cand_id < best_id_q));
		sec_ahead  = !have2_q || (rd_score > sec_score_q) ||
			((rd_score == sec_score_q) && (rd_id < sec_id_q));
	end

	// store entry layout: box edges, score, id
	assign rd_box   = rdata[ENTRY_W-1 -: BOX_W];
	assign rd_score = rdata[IW +: SW];
	assign rd_id    = rdata[IW-1:0];
	assign rd_en    = (state_q == SCAN_RD) && (scan_q != fill_q);

	gnms_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store),
		.waddr (fill_q[AW-1:0]),
		.wdata ({cand_box, cand.confidence, cand.cand_id}),
		.re    (rd_en),
		.raddr (scan_q[AW-1:0]),
		.rdata (rdata)
	);

	assign iou_req.start = (state_q == SCAN_GO);
	assign iou_req.limit = limit_q;

	gnms_iou #(
		.COORD_BITS (COORD_BITS)
	) u_iou (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (iou_req),
		.best_box (best_box_q),
		.cand_box (rd_box),
		.rsp      (iou_rsp)
	);

	assign best_beat = make_beat(best_box_q, best_score_q, best_id_q, 1'b0, !have2_q);
	assign sec_beat  = make_beat(sec_box_q, sec_score_q, sec_id_q, 1'b1, 1'b1);

	always_comb begin
		err_beat          = '0;
		err_beat.status   = err_q;
		err_beat.last_out = 1'b1;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= gnms_pkg::LIMIT_RESET;
			keep_q  <= gnms_pkg::KEEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gnms_pkg::REG_IOU_LIMIT:  limit_q <= cfg_data[gnms_pkg::LIMIT_W-1:0];
				gnms_pkg::REG_KEEP_COUNT: keep_q  <= cfg_data[gnms_pkg::KEEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer: load, walk the store, hand out results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= LOAD;
			fill_q         <= '0;
			best_slot_q    <= '0;
			err_q          <= gnms_pkg::ST_OK;
			scan_q         <= '0;
			have2_q        <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			// output register fills in an emit state and holds while stalled
			result_valid_q <= out_load || (result_valid_q && result_stall);
			unique case (state_q)
				LOAD: begin
					if (cand_fire) begin
						err_q <= err_next;
						if (store) begin
							fill_q <= fill_inc;
							if (ahead) begin
								best_slot_q <= fill_q[AW-1:0];
							end
						end
						if (cand.final_item) begin
							have2_q <= 1'b0;
							if (err_next != gnms_pkg::ST_OK || fill_after == '0) begin
								state_q <= EMIT_ERR;
							end else if (keep_q[1]) begin
								// keep count of two or three: look for a second box
								scan_q  <= '0;
								state_q <= SCAN_RD;
							end else begin
								state_q <= EMIT_BEST;
							end
						end
					end
				end
				SCAN_RD: begin
					if (scan_q == fill_q) begin
						state_q <= EMIT_BEST;
					end else if (scan_q[AW-1:0] == best_slot_q) begin
						// the best box is never its own rival
						scan_q <= scan_q + 1'b1;
					end else begin
						state_q <= SCAN_GO;
					end
				end
				SCAN_GO: state_q <= SCAN_WAIT;
				SCAN_WAIT: begin
					if (iou_rsp.done) begin
						if (!iou_rsp.suppress && sec_ahead) begin
							have2_q <= 1'b1;
						end
						scan_q  <= scan_q + 1'b1;
						state_q <= SCAN_RD;
					end
				end
				EMIT_BEST: begin
					if (out_free) begin
						result_q <= best_beat;
						if (have2_q) begin
							state_q <= EMIT_SECOND;
						end else begin
							fill_q      <= '0;
							best_slot_q <= '0;
							err_q       <= gnms_pkg::ST_OK;
							state_q     <= LOAD;
						end
					end
				end
				EMIT_SECOND: begin
					if (out_free) begin
						result_q    <= sec_beat;
						fill_q      <= '0;
						best_slot_q <= '0;
						err_q       <= gnms_pkg::ST_OK;
						have2_q     <= 1'b0;
						state_q     <= LOAD;
					end
				end
				EMIT_ERR: begin
					if (out_free) begin
						result_q    <= err_beat;
						fill_q      <= '0;
						best_slot_q <= '0;
						err_q       <= gnms_pkg::ST_OK;
						state_q     <= LOAD;
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	// kept box payload, no reset needed
	always_ff @(posedge clk) begin
		if (store && ahead) begin
			best_box_q   <= cand_box;
			best_score_q <= cand.confidence;
			best_id_q    <= cand.cand_id;
		end
		if (state_q == SCAN_WAIT && iou_rsp.done && !iou_rsp.suppress && sec_ahead) begin
			sec_box_q   <= rd_box;
			sec_score_q <= rd_score;
			sec_id_q    <= rd_id;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: design/gnms_checker.sv
// port-level checks for the two-box iou suppression block, bound to the top
`timescale 1ns / 1ps
`include "greedy_iou_nms_top_two_macros.svh"

module gnms_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cand_valid,
	input logic                   cand_stall,
	input gnms_pkg::cand_beat_t   cand,
	input logic                   result_valid,
	input logic                   result_stall,
	input gnms_pkg::result_beat_t result
);

	logic cand_seen;

	assign cand_seen = cand_valid && !cand_stall && cand.final_item;

	// stalled result beat holds
	`GNMS_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result))

	// error beat carries no box and closes the set
	`GNMS_ASSERT_NOW(a_err_beat, clk, arst_n, result_valid && result.status != gnms_pkg::ST_OK, result.rank == 1'b0 && result.last_out && result.out_score == '0 && result.out_id == '0)

	// an accepted first box that is not last is followed at once by the second box
	`GNMS_ASSERT_NEXT(a_second_follows, clk, arst_n, result_valid && !result_stall && !result.last_out, result_valid && result.rank && result.last_out)

	// no candidate is taken while a set still owes its second box
	`GNMS_ASSERT_NOW(a_stall_open_set, clk, arst_n, result_valid && !result.last_out, cand_stall && !cand_seen)

endmodule

bind greedy_iou_nms_top_two gnms_checker u_gnms_checker (.*);
